// ----- hdl/sda_pkg.sv -----
// ----------------------------------------------------------------------------
// sda_pkg
// Shared widths, register and mode codes, and payload types of the spin
// density accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sda_pkg;

	localparam int PT_W       = 12;                     // grid index field
	localparam int AMP_Q_W    = 16;                     // amplitude in Q1.15
	localparam int WEIGHT_W   = 16;                     // weight in Q0.16
	localparam int DEN_W      = 40;                     // density word, Q9.30
	localparam int NCOMP      = 4;                      // total, x, y, z
	localparam int TERM_W     = 34;                     // Q.30 term before weighting
	localparam int PROD_W     = WEIGHT_W + 1 + TERM_W;  // weight times term
	localparam int ROUND_SH   = 16;
	localparam int ROUND_HALF = 1 << (ROUND_SH - 1);
	localparam int INC_W      = PROD_W - ROUND_SH;      // weighted increment
	localparam int SUM_W      = DEN_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DEPTH  = 8;                      // result queue, power of two
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE   = 2'd0,
		CFG_SPIN   = 2'd1,
		CFG_WEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_COLLINEAR = 2'd0,
		MODE_NC_PLAIN  = 2'd1,
		MODE_NC_Z      = 2'd2,
		MODE_NC_FULL   = 2'd3
	} mode_t;

	typedef logic signed [DEN_W-1:0]  den_t;
	typedef den_t [NCOMP-1:0]         den_vec_t;
	typedef logic signed [INC_W-1:0]  inc_t;
	typedef inc_t [NCOMP-1:0]         inc_vec_t;
	typedef logic signed [TERM_W-1:0] term_t;

	// per-component update rule
	typedef struct packed {
		logic [NCOMP-1:0] add_en;
		logic [NCOMP-1:0] clr_en;
	} comp_act_t;

	typedef struct packed {
		logic [PT_W-1:0] point;
		den_vec_t        den;
		logic            sat;
	} result_t;

	localparam den_t DEN_MAX = {1'b0, {(DEN_W-1){1'b1}}};
	localparam den_t DEN_MIN = {1'b1, {(DEN_W-1){1'b0}}};

endpackage

// ----- hdl/sda_combine.sv -----
// ----------------------------------------------------------------------------
// sda_combine
// Adds the weighted increments to the four stored components with
// saturation, or clears or keeps each component as the mode requires.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sda_combine (
	input  sda_pkg::den_vec_t  old_vec,
	input  sda_pkg::inc_vec_t  inc_vec,
	input  sda_pkg::comp_act_t act,
	output sda_pkg::den_vec_t  new_vec,
	output logic               sat
);
	import sda_pkg::*;

	logic signed [SUM_W-1:0] sum [NCOMP];
	logic [NCOMP-1:0]        clip;

	always_comb begin
		for (int c = 0; c < NCOMP; c++) begin
			sum[c]  = SUM_W'($signed(old_vec[c])) + SUM_W'($signed(inc_vec[c]));
			clip[c] = 1'b0;
			if (act.clr_en[c]) begin
				new_vec[c] = '0;
			end else if (act.add_en[c]) begin
				// top two bits disagree: the sum left the 40-bit range
				if (sum[c][SUM_W-1] != sum[c][SUM_W-2]) begin
					clip[c]    = 1'b1;
					new_vec[c] = sum[c][SUM_W-1] ? DEN_MIN : DEN_MAX;
				end else begin
					new_vec[c] = sum[c][DEN_W-1:0];
				end
			end else begin
				new_vec[c] = old_vec[c];
			end
		end
		sat = |clip;
	end

endmodule

// ----- hdl/spin_density_accumulator.sv -----
// ----------------------------------------------------------------------------
// spin_density_accumulator
// Takes one grid point with its up and down spinor amplitudes per cycle,
// while in_stall is low, and read-modify-writes a four-component Q9.30
// density word held in one on-chip memory (one 160-bit word per grid
// point). Throughput is one beat per clock while in_stall is low; a beat
// passes the input, term and weighting registers and the memory read into
// an eight-entry result queue, with up to eight beats in flight. The single
// memory read port and the adder after it set that rate; an update to the
// same point as the beat just ahead is forwarded from the last write. After
// reset the memory is cleared one point per cycle with in_stall high
// meanwhile; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spin_density_accumulator #(
	parameter int GRID_POINTS    = 4096,
	parameter int AMPLITUDE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sda_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sda_pkg::CFG_DATA_W-1:0]       cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [sda_pkg::PT_W-1:0]             grid_index,
	input  logic signed [AMPLITUDE_BITS-1:0]     up_real,
	input  logic signed [AMPLITUDE_BITS-1:0]     up_imag,
	input  logic signed [AMPLITUDE_BITS-1:0]     down_real,
	input  logic signed [AMPLITUDE_BITS-1:0]     down_imag,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sda_pkg::PT_W-1:0]             point_index,
	output logic signed [sda_pkg::DEN_W-1:0]     density_total,
	output logic signed [sda_pkg::DEN_W-1:0]     density_x,
	output logic signed [sda_pkg::DEN_W-1:0]     density_y,
	output logic signed [sda_pkg::DEN_W-1:0]     density_z,
	output logic                                 saturated
);
	import sda_pkg::*;

	localparam int IDX_W       = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
	localparam int RECIP_SH    = 2 * PT_W;
	localparam int RECIP_W     = RECIP_SH + 1;
	localparam int MUL_W       = PT_W + RECIP_W;
	localparam int unsigned RECIP = ((1 << RECIP_SH) + GRID_POINTS - 1) / GRID_POINTS;

	// configuration
	mode_t                 mode_q;
	logic                  spin_q;
	logic [WEIGHT_W-1:0]   weight_q;

	// control
	logic                  in_acc, out_acc;
	logic                  clr_q;
	logic [IDX_W-1:0]      clr_cnt_q;
	logic                  v_s1, v_s2, v_s3;
	logic [OUT_CNT_W-1:0]  cnt_q, fill_q;
	logic [OUT_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;

	// datapath
	logic signed [AMP_Q_W-1:0] ur_in, ui_in, dr_in, di_in;
	logic signed [AMP_Q_W-1:0] ur_s1, ui_s1, dr_s1, di_s1;
	logic [PT_W-1:0]           g_s1;
	logic [PT_W-1:0]           idx_nxt, idx_s2, idx_s3;
	term_t                     term_nxt [NCOMP];
	term_t                     term_s2  [NCOMP];
	logic signed [PROD_W-1:0]  prod     [NCOMP];
	logic signed [PROD_W-1:0]  rnd      [NCOMP];
	inc_vec_t                  inc_nxt, inc_s3;
	den_vec_t                  dens_mem [GRID_POINTS];
	den_vec_t                  rd_data_q;
	logic                      lw_v_q;
	logic [PT_W-1:0]           lw_idx_q;
	den_vec_t                  lw_data_q;
	den_vec_t                  old_vec, new_vec;
	logic                      sat;
	comp_act_t                 act;
	result_t                   res_q [OUT_DEPTH];
	result_t                   head;

	assign cfg_ready = 1'b1;
	assign in_stall  = clr_q || (cnt_q == OUT_CNT_W'(OUT_DEPTH));
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (fill_q != '0);
	assign out_acc   = out_valid && !out_stall;

	// ---------------- amplitude scaling to Q1.15 ----------------
	generate
		if (AMPLITUDE_BITS >= AMP_Q_W) begin : g_amp_down
			assign ur_in = up_real[AMPLITUDE_BITS-1 -: AMP_Q_W];
			assign ui_in = up_imag[AMPLITUDE_BITS-1 -: AMP_Q_W];
			assign dr_in = down_real[AMPLITUDE_BITS-1 -: AMP_Q_W];
			assign di_in = down_imag[AMPLITUDE_BITS-1 -: AMP_Q_W];
		end else begin : g_amp_up
			assign ur_in = {up_real,   {(AMP_Q_W-AMPLITUDE_BITS){1'b0}}};
			assign ui_in = {up_imag,   {(AMP_Q_W-AMPLITUDE_BITS){1'b0}}};
			assign dr_in = {down_real, {(AMP_Q_W-AMPLITUDE_BITS){1'b0}}};
			assign di_in = {down_imag, {(AMP_Q_W-AMPLITUDE_BITS){1'b0}}};
		end
	endgenerate

	// ---------------- grid index reduction ----------------
	generate
		if (GRID_POINTS >= (1 << PT_W)) begin : g_idx_pass
			assign idx_nxt = g_s1;
		end else begin : g_idx_mod
			// quotient by reciprocal, exact for a 12-bit index
			logic [PT_W-1:0] q_s1;
			logic [MUL_W-1:0] q_full;

			assign q_full = MUL_W'(grid_index) * MUL_W'(RECIP);

			always_ff @(posedge clk) begin
				q_s1 <= q_full[RECIP_SH +: PT_W];
			end

			assign idx_nxt = g_s1 - PT_W'(q_s1 * PT_W'(GRID_POINTS));
		end
	endgenerate

	// ---------------- spin terms, Q.30 ----------------
	always_comb begin
		logic signed [2*AMP_Q_W-1:0] p_urur, p_uiui, p_drdr, p_didi;
		logic signed [2*AMP_Q_W-1:0] p_urdr, p_uidi, p_urdi, p_drui;
		term_t n_up, n_dn, n_tot, mx, my, mz;

		p_urur = ur_s1 * ur_s1;
		p_uiui = ui_s1 * ui_s1;
		p_drdr = dr_s1 * dr_s1;
		p_didi = di_s1 * di_s1;
		p_urdr = ur_s1 * dr_s1;
		p_uidi = ui_s1 * di_s1;
		p_urdi = ur_s1 * di_s1;
		p_drui = dr_s1 * ui_s1;

		n_up  = TERM_W'(p_urur) + TERM_W'(p_uiui);
		n_dn  = TERM_W'(p_drdr) + TERM_W'(p_didi);
		n_tot = n_up + n_dn;
		mx    = (TERM_W'(p_urdr) + TERM_W'(p_uidi)) <<< 1;
		my    = (TERM_W'(p_urdi) - TERM_W'(p_drui)) <<< 1;
		mz    = n_up - n_dn;

		term_nxt[0] = (mode_q == MODE_COLLINEAR) ? n_up : n_tot;
		term_nxt[1] = (mode_q == MODE_COLLINEAR) ? n_up : mx;
		term_nxt[2] = my;
		term_nxt[3] = mz;
	end

	// ---------------- weighting with round half up ----------------
	always_comb begin
		for (int c = 0; c < NCOMP; c++) begin
			prod[c]    = $signed({1'b0, weight_q}) * term_s2[c];
			rnd[c]     = prod[c] + $signed(PROD_W'(ROUND_HALF));
			inc_nxt[c] = rnd[c][PROD_W-1:ROUND_SH];
		end
	end

	// ---------------- update rule per mode ----------------
	always_comb begin
		act = '0;
		unique case (mode_q)
			MODE_COLLINEAR: begin
				act.add_en = spin_q ? 4'b0010 : 4'b0001;
			end
			MODE_NC_PLAIN: begin
				act.add_en = 4'b0001;
				act.clr_en = 4'b1110;
			end
			MODE_NC_Z: begin
				act.add_en = 4'b1001;
				act.clr_en = 4'b0110;
			end
			MODE_NC_FULL: begin
				act.add_en = 4'b1111;
			end
		endcase
	end

	// the beat just ahead wrote this point on the edge of our read
	assign old_vec = (lw_v_q && (lw_idx_q == idx_s3)) ? lw_data_q : rd_data_q;

	sda_combine u_combine (
		.old_vec (old_vec),
		.inc_vec (inc_s3),
		.act     (act),
		.new_vec (new_vec),
		.sat     (sat)
	);

	// ---------------- density memory ----------------
	always_ff @(posedge clk) begin
		rd_data_q <= dens_mem[IDX_W'(idx_s2)];
		if (clr_q) begin
			dens_mem[clr_cnt_q] <= '0;
		end else if (v_s3) begin
			dens_mem[IDX_W'(idx_s3)] <= new_vec;
		end
	end

	// ---------------- pipeline payload ----------------
	always_ff @(posedge clk) begin
		ur_s1     <= ur_in;
		ui_s1     <= ui_in;
		dr_s1     <= dr_in;
		di_s1     <= di_in;
		g_s1      <= grid_index;
		idx_s2    <= idx_nxt;
		term_s2   <= term_nxt;
		idx_s3    <= idx_s2;
		inc_s3    <= inc_nxt;
		lw_idx_q  <= idx_s3;
		lw_data_q <= new_vec;
		if (v_s3) begin
			res_q[wr_ptr_q] <= '{point: idx_s3, den: new_vec, sat: sat};
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_COLLINEAR;
			spin_q    <= 1'b0;
			weight_q  <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			lw_v_q    <= 1'b0;
			cnt_q     <= '0;
			fill_q    <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
					CFG_SPIN:   spin_q   <= cfg_data[0];
					CFG_WEIGHT: weight_q <= cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end

			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == IDX_W'(GRID_POINTS - 1)) begin
					clr_q <= 1'b0;
				end
			end

			v_s1   <= in_acc;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			lw_v_q <= v_s3;

			cnt_q  <= cnt_q + OUT_CNT_W'(in_acc) - OUT_CNT_W'(out_acc);
			fill_q <= fill_q + OUT_CNT_W'(v_s3) - OUT_CNT_W'(out_acc);
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	// ---------------- result beat ----------------
	assign head          = res_q[rd_ptr_q];
	assign point_index   = head.point;
	assign density_total = head.den[0];
	assign density_x     = head.den[1];
	assign density_y     = head.den[2];
	assign density_z     = head.den[3];
	assign saturated     = head.sat;

endmodule
